>>> sv/refcounted_page_allocator_unit_defines.svh
// Assertion macros for the reference-counted page allocator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rpa_pkg.sv
// Shared types and constants for the page allocator.
// No dependencies; imported by rpa_ctrl, rpa_dpath and the top level.
package rpa_pkg;

    localparam int NUM_PAGES   = 32768;
    localparam int COUNT_WIDTH = 8;
    localparam int PAGE_SHIFT  = 12;

    localparam int ADDR_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SHARE_W  = 8;
    localparam int FIRST_W  = 20;
    localparam int LIMIT_W  = 21;

    localparam int PAGE_W  = ADDR_W - PAGE_SHIFT;
    localparam int OFF_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    // range arithmetic width: holds page numbers, limit and first + NUM_PAGES
    localparam int CMP_W   = ((PAGE_W > LIMIT_W) ? PAGE_W : LIMIT_W) + 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(1);

    localparam logic [FIRST_W-1:0] FIRST_RESET = FIRST_W'(524288);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(557056);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_SHARE   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADADDR  = 3'd2,
        ST_BADCOUNT = 3'd3,
        ST_BUSY     = 3'd4
    } t_status;

    // which result the datapath registers this cycle
    typedef enum logic [2:0] {
        RES_NONE,
        RES_INIT,
        RES_EMPTY,
        RES_BADADDR,
        RES_UPD
    } t_res;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
    } t_item_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   page_addr;
        logic [SHARE_W-1:0]  share_count;
        logic                page_freed;
    } t_result_beat;

    typedef struct packed {
        logic load_item;
        logic start_init;
        logic init_step;
        logic clr_step;
        logic pop;
        logic cnt_rd_item;
        logic cnt_rd_stack;
        t_res res_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic addr_ok;
        logic depth_zero;
        logic span_empty;
        logic init_last;
        logic clr_last;
    } t_dp_stat;

endpackage

>>> sv/rpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rpa_ctrl.sv
// Command sequencer of the page allocator.
// Depends on rpa_pkg; drives rpa_dpath through t_dp_cmd.
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_ASTK,
        S_UPD
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy;
    t_dp_cmd v_cmd;

    always_comb begin
        n_state            = r_state;
        v_cmd.load_item    = 1'b0;
        v_cmd.start_init   = 1'b0;
        v_cmd.init_step    = 1'b0;
        v_cmd.clr_step     = 1'b0;
        v_cmd.pop          = 1'b0;
        v_cmd.cnt_rd_item  = 1'b0;
        v_cmd.cnt_rd_stack = 1'b0;
        v_cmd.res_sel      = RES_NONE;
        case (r_state)
            S_CLEAR: begin
                v_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    v_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.op)
                    OP_INIT: begin
                        v_cmd.start_init = 1'b1;
                        if (i_stat.span_empty) begin
                            v_cmd.res_sel = RES_INIT;
                            n_state       = S_IDLE;
                        end else begin
                            n_state = S_INIT;
                        end
                    end
                    OP_ALLOC: begin
                        if (i_stat.depth_zero) begin
                            v_cmd.res_sel = RES_EMPTY;
                            n_state       = S_IDLE;
                        end else begin
                            v_cmd.pop = 1'b1;
                            n_state   = S_ASTK;
                        end
                    end
                    OP_SHARE, OP_RELEASE: begin
                        if (!i_stat.addr_ok) begin
                            v_cmd.res_sel = RES_BADADDR;
                            n_state       = S_IDLE;
                        end else begin
                            v_cmd.cnt_rd_item = 1'b1;
                            n_state           = S_UPD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INIT: begin
                v_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    v_cmd.res_sel = RES_INIT;
                    n_state       = S_IDLE;
                end
            end
            S_ASTK: begin
                v_cmd.cnt_rd_stack = 1'b1;
                n_state            = S_UPD;
            end
            S_UPD: begin
                v_cmd.res_sel = RES_UPD;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = v_cmd;
    assign o_busy = r_busy;

endmodule

>>> sv/rpa_dpath.sv
// Datapath of the page allocator: config registers, count and stack memories,
// range checks and result register. Depends on rpa_pkg and rpa_ram.
module rpa_dpath
    import rpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_item_beat            i_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_done,
    output t_result_beat          o_res
);

    logic [FIRST_W-1:0]     r_first;
    logic [LIMIT_W-1:0]     r_limit;
    t_item_beat             r_item;
    logic [OFF_W-1:0]       r_off;
    logic [OFF_W-1:0]       r_idx;
    logic [DEPTH_W-1:0]     r_depth;
    logic                   r_done;
    t_result_beat           r_res;

    logic [CMP_W-1:0]       w_first_x, w_limit_x, w_top, w_lim_eff, w_span;
    logic [CMP_W-1:0]       w_page, w_off_full, w_sum;
    logic [DEPTH_W-1:0]     w_n, w_idx_inc, w_depth_dec;
    logic [OFF_W-1:0]       w_item_off;
    logic                   w_in_range, w_aligned, w_span_empty, w_full;
    t_op                    w_op;

    logic [COUNT_WIDTH-1:0] w_cnt, w_cnt_inc, w_cnt_dec, w_cnt_new;
    logic                   w_cnt_we, w_push;
    logic [OFF_W-1:0]       w_stk_rdata;
    t_result_beat           n_res;

    logic                   w_cram_we, w_cram_re, w_sram_we;
    logic [OFF_W-1:0]       w_cram_waddr, w_cram_raddr, w_sram_waddr, w_sram_wdata;
    logic [COUNT_WIDTH-1:0] w_cram_wdata;

    // span and range checks
    assign w_first_x    = CMP_W'(r_first);
    assign w_limit_x    = CMP_W'(r_limit);
    assign w_top        = w_first_x + CMP_W'(NUM_PAGES);
    assign w_lim_eff    = (w_limit_x > w_top) ? w_top : w_limit_x;
    assign w_span_empty = (w_lim_eff <= w_first_x);
    assign w_span       = w_lim_eff - w_first_x;
    assign w_n          = w_span[DEPTH_W-1:0];

    assign w_op         = t_op'(r_item.cmd);
    assign w_page       = CMP_W'(r_item.addr[ADDR_W-1:PAGE_SHIFT]);
    assign w_in_range   = (w_page >= w_first_x) && (w_page < w_lim_eff);
    assign w_off_full   = w_page - w_first_x;
    assign w_item_off   = w_off_full[OFF_W-1:0];
    assign w_aligned    = (r_item.addr[PAGE_SHIFT-1:0] == '0);

    assign w_idx_inc    = DEPTH_W'(r_idx) + 1'b1;
    assign w_depth_dec  = r_depth - 1'b1;
    assign w_full       = (r_depth == DEPTH_W'(NUM_PAGES));
    assign w_sum        = w_first_x + CMP_W'(r_off);

    assign o_stat.op         = w_op;
    assign o_stat.addr_ok    = w_in_range && ((w_op != OP_RELEASE) || w_aligned);
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.span_empty = w_span_empty;
    assign o_stat.init_last  = (w_idx_inc == w_n);
    assign o_stat.clr_last   = (r_idx == OFF_W'(NUM_PAGES - 1));

    // result and read-modify-write of the count
    assign w_cnt_inc = w_cnt + 1'b1;
    assign w_cnt_dec = w_cnt - 1'b1;

    always_comb begin
        n_res.status      = ST_OK;
        n_res.page_addr   = '0;
        n_res.share_count = '0;
        n_res.page_freed  = 1'b0;
        w_cnt_we          = 1'b0;
        w_cnt_new         = w_cnt;
        w_push            = 1'b0;
        case (i_cmd.res_sel)
            RES_INIT: begin
                n_res.status = ST_OK;
            end
            RES_EMPTY: begin
                n_res.status = ST_EMPTY;
            end
            RES_BADADDR: begin
                n_res.status = ST_BADADDR;
            end
            RES_UPD: begin
                case (w_op)
                    OP_ALLOC: begin
                        if (w_cnt != '0) begin
                            // stale stack entry: dropped, count untouched
                            n_res.status      = ST_BUSY;
                            n_res.share_count = SHARE_W'(w_cnt);
                        end else begin
                            n_res.page_addr   = {w_sum[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
                            n_res.share_count = SHARE_W'(1);
                            w_cnt_we          = 1'b1;
                            w_cnt_new         = COUNT_WIDTH'(1);
                        end
                    end
                    OP_SHARE: begin
                        if (w_cnt == '0) begin
                            n_res.status = ST_BADADDR;
                        end else if (w_cnt == COUNT_MAX) begin
                            n_res.status      = ST_BADCOUNT;
                            n_res.share_count = SHARE_W'(w_cnt);
                        end else begin
                            n_res.share_count = SHARE_W'(w_cnt_inc);
                            w_cnt_we          = 1'b1;
                            w_cnt_new         = w_cnt_inc;
                        end
                    end
                    OP_RELEASE: begin
                        if (w_cnt == '0) begin
                            n_res.status = ST_BADCOUNT;
                        end else begin
                            w_cnt_we  = 1'b1;
                            w_cnt_new = w_cnt_dec;
                            if ((w_cnt_dec == '0) && !w_full) begin
                                w_push           = 1'b1;
                                n_res.page_freed = 1'b1;
                            end else begin
                                n_res.share_count = SHARE_W'(w_cnt_dec);
                            end
                        end
                    end
                    default: begin
                        n_res.status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
    end

    // memory port steering
    assign w_cram_we    = i_cmd.clr_step || i_cmd.init_step || w_cnt_we;
    assign w_cram_waddr = (i_cmd.clr_step || i_cmd.init_step) ? r_idx : r_off;
    assign w_cram_wdata = (i_cmd.clr_step || i_cmd.init_step) ? '0 : w_cnt_new;
    assign w_cram_re    = i_cmd.cnt_rd_item || i_cmd.cnt_rd_stack;
    assign w_cram_raddr = i_cmd.cnt_rd_stack ? w_stk_rdata : w_item_off;

    assign w_sram_we    = i_cmd.init_step || w_push;
    assign w_sram_waddr = i_cmd.init_step ? r_idx : r_depth[OFF_W-1:0];
    assign w_sram_wdata = i_cmd.init_step ? r_idx : r_off;

    rpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cram_we),
        .i_waddr (w_cram_waddr),
        .i_wdata (w_cram_wdata),
        .i_re    (w_cram_re),
        .i_raddr (w_cram_raddr),
        .o_rdata (w_cnt)
    );

    rpa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_sram_we),
        .i_waddr (w_sram_waddr),
        .i_wdata (w_sram_wdata),
        .i_re    (i_cmd.pop),
        .i_raddr (w_depth_dec[OFF_W-1:0]),
        .o_rdata (w_stk_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_RESET;
            r_limit <= LIMIT_RESET;
            r_idx   <= '0;
            r_depth <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST: r_first <= i_cfg_wdata[FIRST_W-1:0];
                    CFG_LIMIT: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    default:   r_limit <= r_limit;
                endcase
            end
            if (i_cmd.start_init) begin
                r_idx   <= '0;
                r_depth <= '0;
            end else if (i_cmd.init_step) begin
                r_idx   <= r_idx + 1'b1;
                r_depth <= w_idx_inc;
            end else if (i_cmd.clr_step) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.pop) begin
                r_depth <= w_depth_dec;
            end else if (w_push) begin
                r_depth <= r_depth + 1'b1;
            end
            r_done <= (i_cmd.res_sel != RES_NONE);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.cnt_rd_item) begin
            r_off <= w_item_off;
        end else if (i_cmd.cnt_rd_stack) begin
            r_off <= w_stk_rdata;
        end
        if (i_cmd.res_sel != RES_NONE) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> sv/refcounted_page_allocator_unit.sv
// Top level of the reference-counted page allocator: sequencer plus datapath.
// Depends on rpa_pkg, rpa_ctrl, rpa_dpath and the assertion macro header.
//
// Usage notes. Commands enter on i_start while o_busy is low; one result beat
// follows on o_done for exactly one cycle and cannot be held off, so capture
// it when it appears. The steps of each command before its result beat,
// during which the next command cannot be taken:
//   init                  : one frame written per cycle across the span
//   alloc, stack empty    : result only
//   alloc                 : stack read, then count read, then write
//   share / release       : count read, then write back
//   bad address           : result only
// The count memory has a registered read, and for alloc the stack read
// must come before the count read.
// After reset the block sweeps the count memory to zero, one entry a cycle,
// with o_busy high. Config writes are taken at any time, but must only be
// issued while no command is outstanding. Counts and stack entries are
// stored as offsets from first_page, so changing first_page moves every
// frame with it.
module refcounted_page_allocator_unit
    import rpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item_beat            i_item,
    // result channel
    output logic                  o_done,
    output t_result_beat          o_res,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "refcounted_page_allocator_unit_defines.svh"

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_alloc_hit;
    logic     w_alloc_one;

    // sequencer: owns o_busy, steps through each command
    rpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // datapath: memories, range checks, result beat register
    rpa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    assign w_alloc_hit = o_done && (o_res.page_addr != '0);
    assign w_alloc_one = (o_res.status == ST_OK) && (o_res.share_count == SHARE_W'(1));

    // a command is accepted in idle and resolved in a later state, so result beats never abut
    `RPA_ASSERT_NXT(a_done_gap, o_done, !o_done, "result beats back to back")

    // an accepted command must make the block busy
    `RPA_ASSERT_NXT(a_accept_busy, i_start && !o_busy, o_busy, "busy not raised on accept")

    // status codes above the busy-top code are never produced
    `RPA_ASSERT_IMP(a_status_code, o_done, o_res.status <= ST_BUSY, "bad status code")

    // a successful alloc hands out the page with a count of one
    `RPA_ASSERT_IMP(a_alloc_count, w_alloc_hit, w_alloc_one, "alloc result inconsistent")

endmodule
